// ----- design/sabb_pkg.sv -----
// ----------------------------------------------------------------------------
// sabb_pkg
// Shared types for the segment versus box overlap pipeline: register indexes
// of the configuration channel and the stage advance group.
// ----------------------------------------------------------------------------
package sabb_pkg;

    localparam int CFG_INDEX_WIDTH = 3;

    // box bound registers, in configuration index order
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_X_LOW  = 3'd0,
        REG_X_HIGH = 3'd1,
        REG_Y_LOW  = 3'd2,
        REG_Y_HIGH = 3'd3,
        REG_Z_LOW  = 3'd4,
        REG_Z_HIGH = 3'd5
    } sabb_reg_t;

    // load enables of the multiply stages, driven by the top level
    typedef struct packed {
        logic pp;    // partial products
        logic prod;  // product sum
        logic comb;  // signed combine into both sides of the test
    } sabb_adv_t;

endpackage

// ----- design/segment_aabb_overlap_test.sv -----
// An input transfer reaches its result on m_tvalid through the six register stages.
// Throughput: one segment per cycle; the six register stages advance together
// as long as the output register is free or is taken in the same cycle.
// Each stage holds its item when the stage after it is full and stalled.
// Reset: synchronous, active low on aresetn; clears all stage valid bits and
// sets the six box bounds to zero. No clearing pass; s_tready is high right after.
// ----------------------------------------------------------------------------
// segment_aabb_overlap_test
// Segment versus axis-aligned box overlap: endpoint containment, three box
// axis tests and three cross-product axis tests on doubled quantities.
// ----------------------------------------------------------------------------
module segment_aabb_overlap_test #(
    parameter int COORD_WIDTH = 32,
    localparam int S_TDATA_WIDTH = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sabb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    // segment input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_TDATA_WIDTH-1:0]            s_tdata,  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata   // hit
);

    localparam int W     = COORD_WIDTH;
    localparam int MAG_W = W + 2;
    localparam int NSTG  = 6;

    // box bounds
    logic signed [W-1:0]    box_lo_reg [3];
    logic signed [W-1:0]    box_hi_reg [3];

    // stage control
    logic [NSTG-1:0]        vld_reg, vld_next;
    logic [NSTG-1:0]        rdy;
    sabb_pkg::sabb_adv_t    adv;

    // stage 1: containment and doubled quantities
    logic signed [W-1:0]    p1 [3];
    logic signed [W-1:0]    p2 [3];
    logic [2:0]             in_a, in_b;
    logic                   hit1_next, hit1_reg;
    logic signed [W:0]      s1_next [3];
    logic signed [W:0]      s1_reg  [3];
    logic signed [W+1:0]    m1_next [3];
    logic signed [W+1:0]    m1_reg  [3];
    logic signed [W:0]      d1_next [3];
    logic signed [W:0]      d1_reg  [3];

    // stage 2: magnitudes and signs
    logic                   hit2_reg;
    logic signed [W:0]      s2_reg [3];
    logic [W:0]             s_abs [3];
    logic [W-1:0]           s_mag2_next [3];
    logic [W-1:0]           s_mag2_reg  [3];
    logic [W+1:0]           m_mag2_next [3];
    logic [W+1:0]           m_mag2_reg  [3];
    logic [W:0]             d_mag2_next [3];
    logic [W:0]             d_mag2_reg  [3];
    logic [2:0]             s_neg2_reg, m_neg2_reg, d_neg2_reg;

    // stages 3 to 6
    logic signed [W+2:0]    ax_lhs [3];
    logic signed [W+2:0]    ax_rhs [3];
    logic                   ax_sep3_next;
    logic                   hit3_reg, hit4_reg, hit5_reg, hit6_reg;
    logic                   ax_sep3_reg, ax_sep4_reg, ax_sep5_reg;
    logic [2:0]             cross_sep;
    logic                   hit6_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_lo_reg[i] <= '0;
                box_hi_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (sabb_pkg::sabb_reg_t'(cfg_index))
                sabb_pkg::REG_X_LOW:  box_lo_reg[0] <= cfg_data;
                sabb_pkg::REG_X_HIGH: box_hi_reg[0] <= cfg_data;
                sabb_pkg::REG_Y_LOW:  box_lo_reg[1] <= cfg_data;
                sabb_pkg::REG_Y_HIGH: box_hi_reg[1] <= cfg_data;
                sabb_pkg::REG_Z_LOW:  box_lo_reg[2] <= cfg_data;
                sabb_pkg::REG_Z_HIGH: box_hi_reg[2] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage advance: a stage loads when it is empty or the next one loads
    always_comb begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_tready = rdy[0];
    assign adv.pp   = rdy[2];
    assign adv.prod = rdy[3];
    assign adv.comb = rdy[4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p1[i] = s_tdata[i*W +: W];
            p2[i] = s_tdata[(i+3)*W +: W];
            in_a[i] = (p1[i] >= box_lo_reg[i]) && (p1[i] <= box_hi_reg[i]);
            in_b[i] = (p2[i] >= box_lo_reg[i]) && (p2[i] <= box_hi_reg[i]);
            s1_next[i] = {box_hi_reg[i][W-1], box_hi_reg[i]}
                       - {box_lo_reg[i][W-1], box_lo_reg[i]};
            m1_next[i] = {{2{p1[i][W-1]}}, p1[i]} + {{2{p2[i][W-1]}}, p2[i]}
                       - {{2{box_lo_reg[i][W-1]}}, box_lo_reg[i]}
                       - {{2{box_hi_reg[i][W-1]}}, box_hi_reg[i]};
            d1_next[i] = {p1[i][W-1], p1[i]} - {p2[i][W-1], p2[i]};
        end
        hit1_next = (&in_a) || (&in_b);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            hit1_reg <= hit1_next;
            for (int i = 0; i < 3; i++) begin
                s1_reg[i] <= s1_next[i];
                m1_reg[i] <= m1_next[i];
                d1_reg[i] <= d1_next[i];
            end
        end
    end

    // stage 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_abs[i]       = s1_reg[i][W] ? -s1_reg[i] : s1_reg[i];
            s_mag2_next[i] = s_abs[i][W-1:0];
            m_mag2_next[i] = m1_reg[i][W+1] ? -m1_reg[i] : m1_reg[i];
            d_mag2_next[i] = d1_reg[i][W] ? -d1_reg[i] : d1_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            hit2_reg <= hit1_reg;
            for (int i = 0; i < 3; i++) begin
                s2_reg[i]      <= s1_reg[i];
                s_mag2_reg[i]  <= s_mag2_next[i];
                m_mag2_reg[i]  <= m_mag2_next[i];
                d_mag2_reg[i]  <= d_mag2_next[i];
                s_neg2_reg[i]  <= s1_reg[i][W];
                m_neg2_reg[i]  <= m1_reg[i][W+1];
                d_neg2_reg[i]  <= d1_reg[i][W];
            end
        end
    end

    // stage 3: box axis tests |M| > S + |D|
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ax_lhs[i] = {1'b0, m_mag2_reg[i]};
            ax_rhs[i] = {{2{s2_reg[i][W]}}, s2_reg[i]} + {2'b00, d_mag2_reg[i]};
        end
        ax_sep3_next = (ax_lhs[0] > ax_rhs[0]) || (ax_lhs[1] > ax_rhs[1])
                    || (ax_lhs[2] > ax_rhs[2]);
    end

    // cross axes: yz, xz, xy
    for (genvar g = 0; g < 3; g++) begin : g_cross
        localparam int A = (g == 0) ? 1 : 0;
        localparam int B = (g == 2) ? 1 : 2;

        sabb_cross #(.COORD_WIDTH(W)) u_cross (
            .aclk   (aclk),
            .adv    (adv),
            .ma_mag (m_mag2_reg[A]),
            .ma_neg (m_neg2_reg[A]),
            .mb_mag (m_mag2_reg[B]),
            .mb_neg (m_neg2_reg[B]),
            .da_mag ({1'b0, d_mag2_reg[A]}),
            .da_neg (d_neg2_reg[A]),
            .db_mag ({1'b0, d_mag2_reg[B]}),
            .db_neg (d_neg2_reg[B]),
            .sa_mag ({2'b00, s_mag2_reg[A]}),
            .sa_neg (s_neg2_reg[A]),
            .sb_mag ({2'b00, s_mag2_reg[B]}),
            .sb_neg (s_neg2_reg[B]),
            .sep    (cross_sep[g])
        );
    end

    assign hit6_next = hit5_reg || !(ax_sep5_reg || (|cross_sep));

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            hit3_reg    <= hit2_reg;
            ax_sep3_reg <= ax_sep3_next;
        end
        if (rdy[3]) begin
            hit4_reg    <= hit3_reg;
            ax_sep4_reg <= ax_sep3_reg;
        end
        if (rdy[4]) begin
            hit5_reg    <= hit4_reg;
            ax_sep5_reg <= ax_sep4_reg;
        end
        if (rdy[5]) begin
            hit6_reg    <= hit6_next;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {7'b0000000, hit6_reg};

`ifndef NO_ASSERTIONS
    // an empty pipeline always takes a segment
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg == '0) |-> s_tready)
        else $error("pipeline empty but input not ready");

    // a stalled middle stage keeps its item
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[4] && !rdy[4]) |=> vld_reg[4])
        else $error("stalled stage dropped its item");

    // endpoint containment travels with the item
    a_contain_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[0] && hit1_reg && rdy[1]) |=> hit2_reg)
        else $error("containment flag lost between stages");

    // a contained endpoint always ends as a hit
    a_contain_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[4] && hit5_reg && rdy[5]) |=> (m_tvalid && m_tdata[0]))
        else $error("contained endpoint reported as miss");
`endif

endmodule

// ----- design/sabb_umul.sv -----
// ----------------------------------------------------------------------------
// sabb_umul
// Two-stage unsigned multiplier: four half-width partial products in the
// first stage, their shifted sum in the second.
// ----------------------------------------------------------------------------
module sabb_umul #(
    parameter int OP_WIDTH = 34
) (
    input  logic                    aclk,
    input  logic                    en_pp,
    input  logic                    en_prod,
    input  logic [OP_WIDTH-1:0]     a,
    input  logic [OP_WIDTH-1:0]     b,
    output logic [2*OP_WIDTH-1:0]   p
);

    localparam int LO_W = (OP_WIDTH + 1) / 2;
    localparam int HI_W = OP_WIDTH - LO_W;
    localparam int PW   = 2 * OP_WIDTH;

    logic [LO_W-1:0]        a_lo, b_lo;
    logic [HI_W-1:0]        a_hi, b_hi;
    logic [2*LO_W-1:0]      ll_next, ll_reg;
    logic [OP_WIDTH-1:0]    lh_next, lh_reg;
    logic [OP_WIDTH-1:0]    hl_next, hl_reg;
    logic [2*HI_W-1:0]      hh_next, hh_reg;
    logic [PW-1:0]          p_next, p_reg;

    assign a_lo = a[LO_W-1:0];
    assign a_hi = a[OP_WIDTH-1:LO_W];
    assign b_lo = b[LO_W-1:0];
    assign b_hi = b[OP_WIDTH-1:LO_W];

    assign ll_next = {{LO_W{1'b0}}, a_lo} * {{LO_W{1'b0}}, b_lo};
    assign lh_next = {{HI_W{1'b0}}, a_lo} * {{LO_W{1'b0}}, b_hi};
    assign hl_next = {{LO_W{1'b0}}, a_hi} * {{HI_W{1'b0}}, b_lo};
    assign hh_next = {{HI_W{1'b0}}, a_hi} * {{HI_W{1'b0}}, b_hi};

    assign p_next = PW'(ll_reg)
                  + (PW'(lh_reg) << LO_W)
                  + (PW'(hl_reg) << LO_W)
                  + (PW'(hh_reg) << (2 * LO_W));

    always_ff @(posedge aclk) begin
        if (en_pp) begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (en_prod) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- design/sabb_cross.sv -----
// ----------------------------------------------------------------------------
// sabb_cross
// One cross-product separating axis: |Ma*Db - Mb*Da| > Sa*|Db| + Sb*|Da|,
// built from operand magnitudes and signs over three register stages.
// ----------------------------------------------------------------------------
module sabb_cross #(
    parameter int COORD_WIDTH = 32,
    localparam int MAG_W = COORD_WIDTH + 2
) (
    input  logic                aclk,
    input  sabb_pkg::sabb_adv_t adv,
    input  logic [MAG_W-1:0]    ma_mag,
    input  logic                ma_neg,
    input  logic [MAG_W-1:0]    mb_mag,
    input  logic                mb_neg,
    input  logic [MAG_W-1:0]    da_mag,
    input  logic                da_neg,
    input  logic [MAG_W-1:0]    db_mag,
    input  logic                db_neg,
    input  logic [MAG_W-1:0]    sa_mag,
    input  logic                sa_neg,
    input  logic [MAG_W-1:0]    sb_mag,
    input  logic                sb_neg,
    output logic                sep
);

    localparam int PW = 2 * MAG_W;
    localparam int LW = PW + 2;

    logic [PW-1:0]          prod [4];
    logic [3:0]             sgn_next, sgn3_reg, sgn4_reg;
    logic signed [LW-1:0]   term [4];
    logic signed [LW-1:0]   lhs_next, rhs_next, lhs_reg, rhs_reg;
    logic signed [LW:0]     lr_sum;

    // terms: Ma*Db, Mb*Da, Sa*|Db|, Sb*|Da|
    sabb_umul #(.OP_WIDTH(MAG_W)) u_mul_madb (
        .aclk(aclk), .en_pp(adv.pp), .en_prod(adv.prod),
        .a(ma_mag), .b(db_mag), .p(prod[0])
    );
    sabb_umul #(.OP_WIDTH(MAG_W)) u_mul_mbda (
        .aclk(aclk), .en_pp(adv.pp), .en_prod(adv.prod),
        .a(mb_mag), .b(da_mag), .p(prod[1])
    );
    sabb_umul #(.OP_WIDTH(MAG_W)) u_mul_sadb (
        .aclk(aclk), .en_pp(adv.pp), .en_prod(adv.prod),
        .a(sa_mag), .b(db_mag), .p(prod[2])
    );
    sabb_umul #(.OP_WIDTH(MAG_W)) u_mul_sbda (
        .aclk(aclk), .en_pp(adv.pp), .en_prod(adv.prod),
        .a(sb_mag), .b(da_mag), .p(prod[3])
    );

    assign sgn_next = {sb_neg, sa_neg, mb_neg ^ da_neg, ma_neg ^ db_neg};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            term[i] = sgn4_reg[i] ? -signed'({2'b00, prod[i]}) : signed'({2'b00, prod[i]});
        end
        lhs_next = term[0] - term[1];
        rhs_next = term[2] + term[3];
    end

    always_ff @(posedge aclk) begin
        if (adv.pp) begin
            sgn3_reg <= sgn_next;
        end
        if (adv.prod) begin
            sgn4_reg <= sgn3_reg;
        end
        if (adv.comb) begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
        end
    end

    // |lhs| > rhs split into lhs > rhs or -lhs > rhs
    assign lr_sum = {lhs_reg[LW-1], lhs_reg} + {rhs_reg[LW-1], rhs_reg};
    assign sep    = (lhs_reg > rhs_reg) || lr_sum[LW];

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment versus box overlap block. Box bounds
// are loaded through the configuration channel between phases. Segments are
// streamed in with random gaps and results are taken with random backpressure.
// Every result is compared in order against a bit-exact software prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_W         = 32;
    localparam int TDATA_W         = 6 * COORD_W;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 113;
    localparam int PRESSURE_AT     = 300;
    localparam int BURST_FROM      = 250;
    localparam int BURST_TO        = 550;
    localparam int LONG_HOLD       = 250;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;

    localparam logic signed [31:0] MAX_C = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN_C = 32'sh8000_0000;
    localparam logic signed [31:0] UNIT  = 32'sh0001_0000;

    typedef logic signed [127:0] wide_t;

    // p1 x at the low end of tdata
    typedef struct packed {
        logic signed [31:0] p2_z;
        logic signed [31:0] p2_y;
        logic signed [31:0] p2_x;
        logic signed [31:0] p1_z;
        logic signed [31:0] p1_y;
        logic signed [31:0] p1_x;
    } segment_t;

    // laid out in register index order from the low end
    typedef struct packed {
        logic signed [31:0] z_high;
        logic signed [31:0] z_low;
        logic signed [31:0] y_high;
        logic signed [31:0] y_low;
        logic signed [31:0] x_high;
        logic signed [31:0] x_low;
    } box_t;

    typedef enum {
        BOX_FULL,
        BOX_INVERTED,
        BOX_POINT,
        BOX_WILD,
        BOX_NORMAL
    } box_style_t;

    class overlap_scoreboard;
        box_t box;
        bit   hit_queue[$];
        int   mismatches;

        function new();
            box = '0;
            mismatches = 0;
        endfunction

        function void write_bound(sabb_pkg::sabb_reg_t idx, logic [31:0] value);
            unique case (idx)
                sabb_pkg::REG_X_LOW:  box.x_low  = value;
                sabb_pkg::REG_X_HIGH: box.x_high = value;
                sabb_pkg::REG_Y_LOW:  box.y_low  = value;
                sabb_pkg::REG_Y_HIGH: box.y_high = value;
                sabb_pkg::REG_Z_LOW:  box.z_low  = value;
                sabb_pkg::REG_Z_HIGH: box.z_high = value;
                default: ;
            endcase
        endfunction

        function wide_t magnitude(wide_t v);
            return (v < 0) ? -v : v;
        endfunction

        // all quantities doubled so the midpoint and half-sizes stay exact
        function bit segment_hits(segment_t s);
            wide_t a[3], b[3], lo[3], hi[3], half[3], mid[3], dir[3];
            bit    in_a, in_b;
            a[0] = $signed(s.p1_x);
            a[1] = $signed(s.p1_y);
            a[2] = $signed(s.p1_z);
            b[0] = $signed(s.p2_x);
            b[1] = $signed(s.p2_y);
            b[2] = $signed(s.p2_z);
            lo[0] = $signed(box.x_low);
            hi[0] = $signed(box.x_high);
            lo[1] = $signed(box.y_low);
            hi[1] = $signed(box.y_high);
            lo[2] = $signed(box.z_low);
            hi[2] = $signed(box.z_high);
            in_a = 1'b1;
            in_b = 1'b1;
            for (int k = 0; k < 3; k++) begin
                in_a &= (a[k] >= lo[k]) && (a[k] <= hi[k]);
                in_b &= (b[k] >= lo[k]) && (b[k] <= hi[k]);
            end
            if (in_a || in_b)
                return 1'b1;
            for (int k = 0; k < 3; k++) begin
                half[k] = hi[k] - lo[k];
                mid[k]  = a[k] + b[k] - lo[k] - hi[k];
                dir[k]  = a[k] - b[k];
                if (magnitude(mid[k]) > half[k] + magnitude(dir[k]))
                    return 1'b0;
            end
            for (int i = 0; i < 2; i++) begin
                for (int j = i + 1; j < 3; j++) begin
                    if (magnitude(mid[i] * dir[j] - mid[j] * dir[i]) >
                        half[i] * magnitude(dir[j]) + half[j] * magnitude(dir[i]))
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_segment(segment_t s);
            hit_queue.push_back(segment_hits(s));
        endfunction

        function void check_result(logic [7:0] data);
            bit want;
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result transfer with nothing expected, hit %0b", data[0]);
                return;
            end
            want = hit_queue.pop_front();
            if (data[0] !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("hit mismatch: expected %0b, got %0b", want, data[0]);
            end
        endfunction

        function int pending();
            return hit_queue.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    sabb_pkg::sabb_reg_t    cfg_index;
    logic [COORD_W-1:0]     cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;

    overlap_scoreboard sb = new();
    int segments_in;
    int cycle_count;

    segment_aabb_overlap_test #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_bound(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                sb.note_segment(segment_t'(s_tdata));
                segments_in++;
            end
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    function automatic logic signed [31:0] saturate_coord(longint v);
        if (v > longint'(MAX_C))
            return MAX_C;
        if (v < longint'(MIN_C))
            return MIN_C;
        return v[31:0];
    endfunction

    // somewhere in the bound interval widened by half its size plus 64 on each side
    function automatic logic signed [31:0] coord_near(logic signed [31:0] a,
                                                      logic signed [31:0] b);
        longint          lo, hi, margin;
        longint unsigned span;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        margin = (hi - lo) / 2 + 64;
        span = hi - lo + 2 * margin + 1;
        return saturate_coord(lo - margin + longint'({$urandom, $urandom} % span));
    endfunction

    function automatic segment_t make_seg(logic signed [31:0] ax, ay, az, bx, by, bz);
        return {bz, by, bx, az, ay, ax};
    endfunction

    function automatic box_t random_box(box_style_t style);
        logic signed [31:0] lo[3], hi[3];
        longint             c, h;
        for (int k = 0; k < 3; k++) begin
            case (style)
                BOX_FULL: begin
                    lo[k] = MIN_C;
                    hi[k] = MAX_C;
                end
                BOX_INVERTED: begin
                    c = $signed($urandom) >>> 8;
                    h = $urandom_range(1, 32'h0010_0000);
                    lo[k] = saturate_coord(c + h);
                    hi[k] = saturate_coord(c - h);
                end
                BOX_POINT: begin
                    lo[k] = $signed($urandom) >>> $urandom_range(0, 20);
                    hi[k] = lo[k];
                end
                BOX_WILD: begin
                    lo[k] = $urandom;
                    hi[k] = $urandom;
                end
                default: begin
                    c = $signed($urandom) >>> $urandom_range(0, 16);
                    h = $urandom_range(0, 32'hffff_ffff >> $urandom_range(4, 30));
                    lo[k] = saturate_coord(c - h);
                    hi[k] = saturate_coord(c + h);
                end
            endcase
        end
        return {hi[2], lo[2], hi[1], lo[1], hi[0], lo[0]};
    endfunction

    function automatic segment_t random_segment(box_t b);
        logic signed [31:0] lo[3], hi[3], p[6];
        int                 r, axis;
        for (int k = 0; k < 3; k++) begin
            lo[k] = b[64*k +: 32];
            hi[k] = b[64*k+32 +: 32];
        end
        r = $urandom_range(0, 99);
        for (int k = 0; k < 6; k++) begin
            axis = k % 3;
            if (r < 15)
                p[k] = $urandom;
            else if (r < 30 && $urandom_range(0, 1) == 1)
                p[k] = ($urandom_range(0, 1) == 1) ? lo[axis] : hi[axis];
            else
                p[k] = coord_near(lo[axis], hi[axis]);
        end
        // zero-length segment now and then
        if ($urandom_range(0, 19) == 0) begin
            p[3] = p[0];
            p[4] = p[1];
            p[5] = p[2];
        end
        return {p[5], p[4], p[3], p[2], p[1], p[0]};
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic offer_segment(segment_t seg, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= seg;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // bounds may only change with nothing in flight
    // wait first so the last transfer is already noted by the monitor
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_box(box_t b);
        for (int i = 0; i < 6; i++) begin
            cfg_index <= sabb_pkg::sabb_reg_t'(i);
            cfg_data  <= b[32*i +: 32];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int stall_len;
        int r;
        bit ready_now;
        bit pressure_done;
        pressure_done = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            r = $urandom_range(0, 99);
            if (!pressure_done && segments_in >= PRESSURE_AT) begin
                ready_now = 1'b0;
                stall_len = LONG_HOLD;
                pressure_done = 1'b1;
            end else if (r < 45) begin
                ready_now = 1'b1;
                stall_len = $urandom_range(1, 6);
            end else if (r < 60) begin
                ready_now = 1'b1;
                stall_len = $urandom_range(20, 80);
            end else if (r < 92) begin
                ready_now = 1'b0;
                stall_len = $urandom_range(1, 3);
            end else begin
                ready_now = 1'b0;
                stall_len = $urandom_range(8, 30);
            end
            m_tready <= ready_now;
            repeat (stall_len) @(posedge aclk);
        end
    end

    initial begin
        box_t box;
        int   item_count;
        int   gap;
        item_count = 0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= sabb_pkg::REG_X_LOW;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // box left at its reset value: a single point at the origin
        offer_segment(make_seg(0, 0, 0, 0, 0, 0), random_gap());
        offer_segment(make_seg(-1, 0, 0, 1, 0, 0), random_gap());
        offer_segment(make_seg(1, 1, 1, 2, 2, 2), random_gap());
        offer_segment(make_seg(MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C), random_gap());
        offer_segment(make_seg(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C), random_gap());
        offer_segment(make_seg(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C), random_gap());
        finish_phase();

        write_box({UNIT, -UNIT, UNIT, -UNIT, UNIT, -UNIT});
        offer_segment(make_seg(0, 0, 0, UNIT / 2, 1, 1), random_gap());
        offer_segment(make_seg(UNIT, UNIT, UNIT, 3 * UNIT, 3 * UNIT, 3 * UNIT), random_gap());
        offer_segment(make_seg(-UNIT, -UNIT, -UNIT, MIN_C, MIN_C, MIN_C), random_gap());
        offer_segment(make_seg(-2 * UNIT, 0, 0, 2 * UNIT, 0, 0), random_gap());
        offer_segment(make_seg(2 * UNIT, 0, 0, 3 * UNIT, 0, 0), random_gap());
        offer_segment(make_seg(0, 2 * UNIT, 0, 0, 3 * UNIT, 0), random_gap());
        offer_segment(make_seg(0, 0, -3 * UNIT, 0, 0, -2 * UNIT), random_gap());
        offer_segment(make_seg(UNIT + 1, 0, 0, UNIT + 1, 0, 0), random_gap());
        // misses only on the cross-product axes, one per plane
        offer_segment(make_seg(0, UNIT * 5 / 2, 0, UNIT * 5 / 2, 0, 0), random_gap());
        offer_segment(make_seg(0, 0, UNIT * 5 / 2, 0, UNIT * 5 / 2, 0), random_gap());
        offer_segment(make_seg(UNIT * 5 / 2, 0, 0, 0, 0, UNIT * 5 / 2), random_gap());
        // grazes the box edge exactly, not separated
        offer_segment(make_seg(0, 2 * UNIT, 0, 2 * UNIT, 0, 0), random_gap());
        offer_segment(make_seg(MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C), random_gap());
        offer_segment(make_seg(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                               32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA), random_gap());
        finish_phase();

        for (int ph = 0; ph < PHASES; ph++) begin
            box = random_box((ph < BOX_NORMAL) ? box_style_t'(ph) : BOX_NORMAL);
            write_box(box);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // back-to-back offers around the long hold-off so the pipe fills
                if (item_count >= BURST_FROM && item_count < BURST_TO)
                    gap = 0;
                else
                    gap = random_gap();
                offer_segment(random_segment(box), gap);
                item_count++;
            end
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
